FILE: rtl/core/urbe_pkg.sv
// ----------------------------------------------------------------------------
// urbe_pkg
// Shared types and codes for the UART ring buffer engine.
// ----------------------------------------------------------------------------
package urbe_pkg;

   // Item kinds as they arrive on the request channel
   localparam logic [1:0] KIND_WRITE = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_EVENT = 2'd2;

   // Positions of the error flags and their counters
   localparam int ERR_OVERRUN = 0;
   localparam int ERR_FRAMING = 1;
   localparam int ERR_NOISE   = 2;
   localparam int ERR_PARITY  = 3;
   localparam int NUM_ERR     = 4;

   localparam int CNT_W = 16;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_EVENT = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   // Classified command handed from the front queue to the back end
   typedef struct packed {
      op_type             op;
      logic [7:0]         data;
      logic [NUM_ERR-1:0] err;
      logic               rx_ready;
      logic               tx_empty;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } back_state_type;

endpackage

FILE: rtl/core/uart_ring_buffer_engine.sv
// ----------------------------------------------------------------------------
// uart_ring_buffer_engine
// Transmit and receive byte rings for a UART, driven by host and irq items.
// ----------------------------------------------------------------------------
//
//   channel   handshake             carries
//   req_      req_valid/req_ready   kind, data_in, six status flags
//   rsp_      rsp_valid/rsp_ready   per-item flags and bytes, enable, counters
//
// Each transaction passes through the back end in order: on issue (ST_IDLE)
// the ring tail entries are read into the registered memory outputs, then
// ST_EXEC commits it; a new item is issued only after the last has committed.
// A two-entry command queue absorbs up to two transactions while the back end
// or a stalled response holds; req_ready drops once both entries are taken.
// Reset (synchronous) clears pointers, the enable and all counters; ring
// contents are not cleared and need no clearing pass.
// A held response stalls only the commit step; the queue fills, then holds.
//
module uart_ring_buffer_engine #(
   parameter int RING_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_data_in,
   input  logic        req_flag_overrun,
   input  logic        req_flag_framing,
   input  logic        req_flag_noise,
   input  logic        req_flag_parity,
   input  logic        req_flag_rx_ready,
   input  logic        req_flag_tx_empty,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_write_accepted,
   output logic        rsp_read_valid,
   output logic [7:0]  rsp_read_byte,
   output logic        rsp_send_valid,
   output logic [7:0]  rsp_send_byte,
   output logic        rsp_tx_irq_enabled,
   output logic [15:0] rsp_rx_drops,
   output logic [15:0] rsp_tx_drops,
   output logic [15:0] rsp_overrun_errors,
   output logic [15:0] rsp_framing_errors,
   output logic [15:0] rsp_noise_errors,
   output logic [15:0] rsp_parity_errors
);

   // Command queue handoff between front and back
   logic              cmd_valid;
   logic              cmd_ready;
   urbe_pkg::cmd_type cmd;

   // Front: accept the transaction, classify it, queue it
   urbe_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_data_in       (req_data_in),
      .req_flag_overrun  (req_flag_overrun),
      .req_flag_framing  (req_flag_framing),
      .req_flag_noise    (req_flag_noise),
      .req_flag_parity   (req_flag_parity),
      .req_flag_rx_ready (req_flag_rx_ready),
      .req_flag_tx_empty (req_flag_tx_empty),
      .cmd_valid         (cmd_valid),
      .cmd_ready         (cmd_ready),
      .cmd               (cmd)
   );

   // Back: own the rings and counters, hold the response register
   urbe_back #(
      .RING_DEPTH (RING_DEPTH)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .cmd_valid          (cmd_valid),
      .cmd_ready          (cmd_ready),
      .cmd                (cmd),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_write_accepted (rsp_write_accepted),
      .rsp_read_valid     (rsp_read_valid),
      .rsp_read_byte      (rsp_read_byte),
      .rsp_send_valid     (rsp_send_valid),
      .rsp_send_byte      (rsp_send_byte),
      .rsp_tx_irq_enabled (rsp_tx_irq_enabled),
      .rsp_rx_drops       (rsp_rx_drops),
      .rsp_tx_drops       (rsp_tx_drops),
      .rsp_overrun_errors (rsp_overrun_errors),
      .rsp_framing_errors (rsp_framing_errors),
      .rsp_noise_errors   (rsp_noise_errors),
      .rsp_parity_errors  (rsp_parity_errors)
   );

   // A result reports at most one of write, read and send
   a_one_action: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({rsp_write_accepted, rsp_read_valid, rsp_send_valid}))
      else $error("more than one action in one result");

   // Bytes are zero unless their valid flag is set
   a_zero_bytes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_read_valid || rsp_read_byte == 8'd0) &&
                     (rsp_send_valid || rsp_send_byte == 8'd0)))
      else $error("byte present without its valid flag");

   // An accepted write always leaves the transmit enable set
   a_write_enables: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_write_accepted |-> rsp_tx_irq_enabled)
      else $error("write accepted with enable clear");

   // A send can only happen while the enable stays set
   a_send_enabled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_send_valid |-> rsp_tx_irq_enabled)
      else $error("byte sent with enable clear");

endmodule

FILE: rtl/core/urbe_front.sv
// ----------------------------------------------------------------------------
// urbe_front
// Accepts request transactions, classifies them and queues up to two commands.
// ----------------------------------------------------------------------------
module urbe_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_kind,
   input  logic [7:0]        req_data_in,
   input  logic              req_flag_overrun,
   input  logic              req_flag_framing,
   input  logic              req_flag_noise,
   input  logic              req_flag_parity,
   input  logic              req_flag_rx_ready,
   input  logic              req_flag_tx_empty,
   output logic              cmd_valid,
   input  logic              cmd_ready,
   output urbe_pkg::cmd_type cmd
);

   urbe_pkg::cmd_type q_ff [2];
   urbe_pkg::cmd_type q_in;
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic              push, pop;
   urbe_pkg::cmd_type cls;

   // Classify: flags only matter on events, unused kinds become no-ops
   always_comb begin
      cls          = '0;
      cls.data     = req_data_in;
      case (req_kind)
         urbe_pkg::KIND_WRITE: begin
            cls.op = urbe_pkg::OP_WRITE;
         end
         urbe_pkg::KIND_READ: begin
            cls.op = urbe_pkg::OP_READ;
         end
         urbe_pkg::KIND_EVENT: begin
            cls.op       = urbe_pkg::OP_EVENT;
            cls.err      = {req_flag_parity, req_flag_noise,
                            req_flag_framing, req_flag_overrun};
            cls.rx_ready = req_flag_rx_ready;
            cls.tx_empty = req_flag_tx_empty;
         end
         default: begin
            cls.op = urbe_pkg::OP_NOP;
         end
      endcase
   end

   assign req_ready = (cnt_ff != 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = cmd_valid && cmd_ready;

   always_comb begin
      q_in      = cls;
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= q_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

FILE: rtl/core/urbe_back.sv
// ----------------------------------------------------------------------------
// urbe_back
// Executes commands against the two rings and the counters, holds the result.
// ----------------------------------------------------------------------------
module urbe_back #(
   parameter int RING_DEPTH = 256
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       cmd_valid,
   output logic                       cmd_ready,
   input  urbe_pkg::cmd_type          cmd,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_write_accepted,
   output logic                       rsp_read_valid,
   output logic [7:0]                 rsp_read_byte,
   output logic                       rsp_send_valid,
   output logic [7:0]                 rsp_send_byte,
   output logic                       rsp_tx_irq_enabled,
   output logic [urbe_pkg::CNT_W-1:0] rsp_rx_drops,
   output logic [urbe_pkg::CNT_W-1:0] rsp_tx_drops,
   output logic [urbe_pkg::CNT_W-1:0] rsp_overrun_errors,
   output logic [urbe_pkg::CNT_W-1:0] rsp_framing_errors,
   output logic [urbe_pkg::CNT_W-1:0] rsp_noise_errors,
   output logic [urbe_pkg::CNT_W-1:0] rsp_parity_errors
);

   localparam int PTR_W = $clog2(RING_DEPTH);
   localparam int CW    = urbe_pkg::CNT_W;

   logic [7:0] tx_mem [RING_DEPTH];
   logic [7:0] rx_mem [RING_DEPTH];

   urbe_pkg::back_state_type state_ff, state_in;
   urbe_pkg::cmd_type        cur_ff;
   logic [7:0]               tx_rd_ff, rx_rd_ff;

   logic [PTR_W-1:0] tx_head_ff, tx_head_in, tx_tail_ff, tx_tail_in;
   logic [PTR_W-1:0] rx_head_ff, rx_head_in, rx_tail_ff, rx_tail_in;
   logic             en_ff, en_in;
   logic [CW-1:0]    rx_drop_ff, rx_drop_in, tx_drop_ff, tx_drop_in;
   logic [CW-1:0]    err_cnt_ff [urbe_pkg::NUM_ERR];
   logic [CW-1:0]    err_cnt_in [urbe_pkg::NUM_ERR];

   logic       rsp_valid_ff, rsp_valid_in;
   logic       wr_ok_ff, wr_ok_in, rd_ok_ff, rd_ok_in, sd_ok_ff, sd_ok_in;
   logic [7:0] rd_byte_ff, rd_byte_in, sd_byte_ff, sd_byte_in;

   logic issue, commit;
   logic tx_we, rx_we;
   logic tx_full, rx_full, any_err;
   logic [CW-1:0] err_sum;

   assign issue     = (state_ff == urbe_pkg::ST_IDLE) && cmd_valid;
   assign cmd_ready = issue;
   assign commit    = (state_ff == urbe_pkg::ST_EXEC) && (!rsp_valid_ff || rsp_ready);

   assign tx_full = ((tx_head_ff + PTR_W'(1)) == tx_tail_ff);
   assign rx_full = ((rx_head_ff + PTR_W'(1)) == rx_tail_ff);
   assign any_err = |cur_ff.err;
   assign err_sum = CW'(cur_ff.err[urbe_pkg::ERR_OVERRUN]) +
                    CW'(cur_ff.err[urbe_pkg::ERR_FRAMING]) +
                    CW'(cur_ff.err[urbe_pkg::ERR_NOISE]) +
                    CW'(cur_ff.err[urbe_pkg::ERR_PARITY]);

   always_comb begin
      state_in     = state_ff;
      tx_head_in   = tx_head_ff;
      tx_tail_in   = tx_tail_ff;
      rx_head_in   = rx_head_ff;
      rx_tail_in   = rx_tail_ff;
      en_in        = en_ff;
      rx_drop_in   = rx_drop_ff;
      tx_drop_in   = tx_drop_ff;
      err_cnt_in   = err_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      wr_ok_in     = 1'b0;
      rd_ok_in     = 1'b0;
      sd_ok_in     = 1'b0;
      rd_byte_in   = 8'd0;
      sd_byte_in   = 8'd0;
      tx_we        = 1'b0;
      rx_we        = 1'b0;

      case (state_ff)
         urbe_pkg::ST_IDLE: begin
            if (issue) begin
               state_in = urbe_pkg::ST_EXEC;
            end
         end
         urbe_pkg::ST_EXEC: begin
            if (commit) begin
               state_in     = urbe_pkg::ST_IDLE;
               rsp_valid_in = 1'b1;
               case (cur_ff.op)
                  urbe_pkg::OP_WRITE: begin
                     if (tx_full) begin
                        tx_drop_in = tx_drop_ff + CW'(1);
                     end else begin
                        tx_we      = 1'b1;
                        tx_head_in = tx_head_ff + PTR_W'(1);
                        en_in      = 1'b1;
                        wr_ok_in   = 1'b1;
                     end
                  end
                  urbe_pkg::OP_READ: begin
                     if (rx_tail_ff != rx_head_ff) begin
                        rd_ok_in   = 1'b1;
                        rd_byte_in = rx_rd_ff;
                        rx_tail_in = rx_tail_ff + PTR_W'(1);
                     end
                  end
                  urbe_pkg::OP_EVENT: begin
                     for (int i = 0; i < urbe_pkg::NUM_ERR; i++) begin
                        err_cnt_in[i] = err_cnt_ff[i] + CW'(cur_ff.err[i]);
                     end
                     if (any_err) begin
                        rx_drop_in = rx_drop_ff + err_sum;
                     end else if (cur_ff.rx_ready) begin
                        if (rx_full) begin
                           rx_drop_in = rx_drop_ff + CW'(1);
                        end else begin
                           rx_we      = 1'b1;
                           rx_head_in = rx_head_ff + PTR_W'(1);
                        end
                     end
                     if (cur_ff.tx_empty && en_ff) begin
                        if (tx_tail_ff != tx_head_ff) begin
                           sd_ok_in   = 1'b1;
                           sd_byte_in = tx_rd_ff;
                           tx_tail_in = tx_tail_ff + PTR_W'(1);
                        end else begin
                           en_in = 1'b0;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
            state_in = urbe_pkg::ST_IDLE;
         end
      endcase
   end

   // Ring storage: write on commit, read the tail entries on issue
   always_ff @(posedge clock) begin
      if (tx_we) begin
         tx_mem[tx_head_ff] <= cur_ff.data;
      end
      if (issue) begin
         tx_rd_ff <= tx_mem[tx_tail_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (rx_we) begin
         rx_mem[rx_head_ff] <= cur_ff.data;
      end
      if (issue) begin
         rx_rd_ff <= rx_mem[rx_tail_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         cur_ff <= cmd;
      end
      if (commit) begin
         wr_ok_ff   <= wr_ok_in;
         rd_ok_ff   <= rd_ok_in;
         sd_ok_ff   <= sd_ok_in;
         rd_byte_ff <= rd_byte_in;
         sd_byte_ff <= sd_byte_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= urbe_pkg::ST_IDLE;
         tx_head_ff   <= '0;
         tx_tail_ff   <= '0;
         rx_head_ff   <= '0;
         rx_tail_ff   <= '0;
         en_ff        <= 1'b0;
         rx_drop_ff   <= '0;
         tx_drop_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < urbe_pkg::NUM_ERR; i++) begin
            err_cnt_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         tx_head_ff   <= tx_head_in;
         tx_tail_ff   <= tx_tail_in;
         rx_head_ff   <= rx_head_in;
         rx_tail_ff   <= rx_tail_in;
         en_ff        <= en_in;
         rx_drop_ff   <= rx_drop_in;
         tx_drop_ff   <= tx_drop_in;
         rsp_valid_ff <= rsp_valid_in;
         err_cnt_ff   <= err_cnt_in;
      end
   end

   // Counters and the enable change only on commit, so they hold with the result
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_write_accepted = wr_ok_ff;
   assign rsp_read_valid     = rd_ok_ff;
   assign rsp_read_byte      = rd_byte_ff;
   assign rsp_send_valid     = sd_ok_ff;
   assign rsp_send_byte      = sd_byte_ff;
   assign rsp_tx_irq_enabled = en_ff;
   assign rsp_rx_drops       = rx_drop_ff;
   assign rsp_tx_drops       = tx_drop_ff;
   assign rsp_overrun_errors = err_cnt_ff[urbe_pkg::ERR_OVERRUN];
   assign rsp_framing_errors = err_cnt_ff[urbe_pkg::ERR_FRAMING];
   assign rsp_noise_errors   = err_cnt_ff[urbe_pkg::ERR_NOISE];
   assign rsp_parity_errors  = err_cnt_ff[urbe_pkg::ERR_PARITY];

endmodule
